// ===== rtl/core/ecgr_pkg.sv =====
// Shared types and constants for the ECG R-peak and heart rate block.
package ecgr_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 12;
  localparam int INDEX_BITS  = 24;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int RATE_BITS   = 24;

  // Heart rate scaling: hundredths of bpm per hertz of sampling
  localparam int CENTI_PER_MIN = 6000;
  localparam int K_BITS        = 25;                  // 6000 * 4095 fits 25 bits
  localparam int DVD_BITS      = COUNT_BITS + K_BITS; // full dividend width
  localparam int STEP_BITS     = $clog2(DVD_BITS);

  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = CFG_BITS'(1150);
  localparam logic [CFG_BITS-1:0] RATE_HZ_RESET   = CFG_BITS'(360);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [K_BITS-1:0]      k_t;
  typedef logic [DVD_BITS-1:0]    dvd_t;
  typedef logic [RATE_BITS-1:0]   rate_t;

  localparam rate_t RATE_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PEAK_THRESHOLD = 2'd0,
    CFG_SAMPLE_RATE    = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    sample_t sample;
    logic    end_of_record;
  } in_item_t;

  typedef struct packed {
    logic    peak_flag;
    sample_t peak_value;
    index_t  peak_index;
    logic    rate_valid;
    rate_t   heart_rate_centi_bpm;
    logic    rate_error;
    logic    rate_saturated;
  } out_item_t;

  // Divider status back to the control
  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

// ===== rtl/core/ecgr_div.sv =====
// Bit-serial restoring divider with saturation of the quotient to the rate width.
module ecgr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ecgr_pkg::dvd_t    dividend,
  input  ecgr_pkg::index_t  divisor,
  output ecgr_pkg::div_stat_t stat,
  output ecgr_pkg::rate_t   quotient
);
  import ecgr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_BITS-1:0] step_r;
  dvd_t                 dvd_r;
  index_t               dsr_r;
  index_t               rem_r;
  rate_t                q_r;
  logic                 ovf_r;

  logic [INDEX_BITS:0]  shifted;
  logic [INDEX_BITS:0]  diff;
  logic                 qbit;
  index_t               rem_nxt;

  // One quotient bit per cycle, dividend bits shifted in from the top
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_BITS-1]};
    diff    = shifted - {1'b0, dsr_r};
    qbit    = (shifted >= {1'b0, dsr_r});
    rem_nxt = qbit ? diff[INDEX_BITS-1:0] : shifted[INDEX_BITS-1:0];
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(DVD_BITS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[RATE_BITS-2:0], qbit};
      // a set bit pushed past the top means the quotient does not fit
      ovf_r <= ovf_r | q_r[RATE_BITS-1];
    end
  end

  assign stat.done = done_r;
  assign stat.sat  = ovf_r;
  assign quotient  = ovf_r ? RATE_MAX : q_r;

endmodule

// ===== rtl/core/ecg_r_peak_heart_rate.sv =====
// Top level: ECG R-peak detector with average heart rate per record.
//
// Samples enter on the in_ channel (valid/ready), one result per sample leaves
// on the out_ channel through a single output register. A sample is judged as
// a peak candidate when its right-hand neighbour arrives, so a peak shows up in
// the result of the following sample, with its value and index in the record.
// Ordinary samples: result is registered in the cycle after the request is taken,
// and a new sample is taken every cycle while the receiver keeps up.
// End of record with two or more distinct peak positions: the rate is
// count*6000*rate_hz/span, built in the multiply states ST_MULK and ST_MULP and a
// bit-serial divider of 41 steps; in_ready stays low until the result is
// registered. Other record ends are registered like ordinary samples.
// in_ready also drops while a result waits in the output register and the
// receiver stalls; nothing is lost or repeated.
// cfg_ writes are always taken and should be made while the block is idle.
// Reset (rst_n low, synchronous) loads threshold 1150, rate 360 Hz and clears
// the record state and the output valid flag.
module ecg_r_peak_heart_rate (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ecgr_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ecgr_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ecgr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ecgr_pkg::CFG_BITS-1:0]     cfg_data
);
  import ecgr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MULK = 4'b0010,
    ST_MULP = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  localparam index_t IDX_MAX = '1;
  localparam count_t CNT_MAX = '1;

  state_t  state_r, state_nxt;
  logic [CFG_BITS-1:0] thr_r, rate_hz_r;

  sample_t center_r, older_r;
  index_t  idx_r, first_r, last_r;
  count_t  cnt_r;
  logic    seen_r;

  sample_t center_nxt, older_nxt;
  index_t  idx_nxt, first_nxt, last_nxt;
  count_t  cnt_nxt;
  logic    seen_nxt;

  index_t  first_upd, last_upd, idx_upd, at;
  count_t  cnt_upd;
  logic    seen_upd, is_peak, span_zero;

  out_item_t out_r, out_nxt, item;
  logic      out_valid_r, out_valid_nxt;

  count_t  cnt_op_r;
  index_t  span_op_r;
  k_t      k_r;
  out_item_t pend_r;

  logic    accept, div_start;
  div_stat_t div_stat;
  rate_t   div_q;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      rate_hz_r <= RATE_HZ_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PEAK_THRESHOLD: thr_r     <= cfg_data;
        CFG_SAMPLE_RATE:    rate_hz_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Peak test on the center sample and record updates
  always_comb begin
    is_peak   = (idx_r >= INDEX_BITS'(2)) && (center_r > thr_r) &&
                (center_r > older_r) && (center_r > in_data.sample);
    at        = idx_r - 1'b1;
    cnt_upd   = (is_peak && cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    first_upd = (is_peak && !seen_r) ? at : first_r;
    last_upd  = is_peak ? at : last_r;
    seen_upd  = seen_r | is_peak;
    idx_upd   = (idx_r != IDX_MAX) ? idx_r + 1'b1 : idx_r;
    span_zero = !seen_upd || (last_upd == first_upd);

    item = '0;
    item.peak_flag  = is_peak;
    item.peak_value = is_peak ? center_r : '0;
    item.peak_index = is_peak ? at : '0;
    if (in_data.end_of_record) begin
      item.rate_valid = 1'b1;
      item.rate_error = span_zero;
    end

    center_nxt = center_r;
    older_nxt  = older_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    seen_nxt   = seen_r;
    if (accept) begin
      if (in_data.end_of_record) begin
        center_nxt = '0;
        older_nxt  = '0;
        idx_nxt    = '0;
        cnt_nxt    = '0;
        first_nxt  = '0;
        last_nxt   = '0;
        seen_nxt   = 1'b0;
      end else begin
        center_nxt = in_data.sample;
        older_nxt  = center_r;
        idx_nxt    = idx_upd;
        cnt_nxt    = cnt_upd;
        first_nxt  = first_upd;
        last_nxt   = last_upd;
        seen_nxt   = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      older_r  <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
      first_r  <= '0;
      last_r   <= '0;
      seen_r   <= 1'b0;
    end else begin
      center_r <= center_nxt;
      older_r  <= older_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Sequencer for the end-of-record rate
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && in_data.end_of_record && !span_zero) state_nxt = ST_MULK;
      ST_MULK: state_nxt = ST_MULP;
      ST_MULP: state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Rate operands: span and count captured at the request, scale factor next
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_op_r  <= cnt_upd;
      span_op_r <= last_upd - first_upd;
      pend_r    <= item;
    end
    if (state_r == ST_MULK) begin
      k_r <= k_t'(rate_hz_r) * k_t'(CENTI_PER_MIN);
    end
  end

  assign div_start = (state_r == ST_MULP);

  ecgr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_t'(cnt_op_r) * dvd_t'(k_r)),
    .divisor  (span_op_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept && !(in_data.end_of_record && !span_zero)) begin
      out_nxt       = item;
      out_valid_nxt = 1'b1;
    end else if (state_r == ST_DIV && div_stat.done) begin
      out_nxt = pend_r;
      out_nxt.heart_rate_centi_bpm = div_q;
      out_nxt.rate_saturated       = div_stat.sat;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_out_free_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_stat.done) |-> !out_valid_r)
    else $error("rate result would overwrite a pending result");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rate_saturated) |-> out_r.heart_rate_centi_bpm == RATE_MAX)
    else $error("saturated rate not at full scale");

  a_record_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.end_of_record) |=> (idx_r == '0 && !seen_r && cnt_r == '0))
    else $error("record state not cleared after end of record");

endmodule
